// File: rtl/spa_pkg.sv
// Shared types and codes for the sparse pattern assembler.
// Used by sparse_pattern_assembler; no dependencies.
package spa_pkg;

   localparam logic [2:0] REQ_INSERT = 3'd0;
   localparam logic [2:0] REQ_BUILD  = 3'd1;
   localparam logic [2:0] REQ_ADD    = 3'd2;
   localparam logic [2:0] REQ_RHS    = 3'd3;
   localparam logic [2:0] REQ_ENTRY  = 3'd4;
   localparam logic [2:0] REQ_GROUP  = 3'd5;

   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_FULL     = 3'd1;
   localparam logic [2:0] STS_NOTFOUND = 3'd2;
   localparam logic [2:0] STS_RANGE    = 3'd3;
   localparam logic [2:0] STS_PHASE    = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SORT_LD,
      ST_SORT_GET,
      ST_SORT_CMP,
      ST_SORT_PUT,
      ST_DD,
      ST_GP_RD,
      ST_GP,
      ST_V_HI,
      ST_V_START,
      ST_V_SCAN,
      ST_V_WAIT,
      ST_V_ADDS,
      ST_V_ADDM,
      ST_R_ADD,
      ST_E_WAIT,
      ST_E_GET,
      ST_G_GET,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         minor;
      logic signed [31:0] ks;
      logic signed [31:0] ms;
      logic [10:0]        gs;
      logic signed [31:0] rs;
      logic [10:0]        entries;
      logic [8:0]         groups;
   } result_type;

endpackage

// File: rtl/sparse_pattern_assembler.sv
// Sparse pattern assembler: coordinate inserts, in-place build to CSR/CSC, value adds.
// Depends on spa_pkg.
//
// One item at a time. A value add scans the entries of the major group one by one.
// Build: insertion sort on the coordinate memory, one shift per step for each entry,
// then a pass of dedup and value clearing, then a pointer and rhs sweep. All
// saturating adds go through one shared 32-bit adder. req_stall is high while busy.
module sparse_pattern_assembler #(
   parameter int MAX_ENTRIES = 1024,
   parameter int MAX_DIM     = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_column_major,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic [7:0]         req_row,
   input  logic [7:0]         req_col,
   input  logic signed [31:0] req_stiff_value,
   input  logic signed [31:0] req_mass_value,
   input  logic signed [31:0] req_rhs_value,
   input  logic [10:0]        req_read_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_minor_index,
   output logic signed [31:0] rsp_stiff_sum,
   output logic signed [31:0] rsp_mass_sum,
   output logic [10:0]        rsp_group_start,
   output logic signed [31:0] rsp_rhs_sum,
   output logic [10:0]        rsp_entry_count,
   output logic [8:0]         rsp_group_count
);
   import spa_pkg::*;

   localparam int EW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int GA = $clog2(MAX_DIM + 1);
   localparam int DA = $clog2(MAX_DIM);

   function automatic logic [7:0] major_of(logic [15:0] c, logic csc);
      return csc ? c[7:0] : c[15:8];
   endfunction

   function automatic logic [7:0] minor_of(logic [15:0] c, logic csc);
      return csc ? c[15:8] : c[7:0];
   endfunction

   function automatic logic [15:0] key_of(logic [15:0] c, logic csc);
      return csc ? {c[7:0], c[15:8]} : c;
   endfunction

   function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      return s[31:0];
   endfunction

   logic [15:0] coord_mem [MAX_ENTRIES];
   logic [31:0] stiff_mem [MAX_ENTRIES];
   logic [31:0] mass_mem  [MAX_ENTRIES];
   logic [CW-1:0] gp_mem  [MAX_DIM + 1];
   logic [31:0] rhs_mem   [MAX_DIM];

   state_type   state_ff, state_in;
   logic        cm_ff, cm_in;
   logic        built_ff, built_in;
   logic        csc_ff, csc_in;
   logic [CW-1:0] stored_ff, stored_in;
   logic [GA-1:0] groups_ff, groups_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, hi_ff, hi_in, idx_ff, idx_in;
   logic [GA-1:0] m_ff, m_in;
   logic [15:0] cur_ff, cur_in, last_ff, last_in;
   logic [7:0]  row_ff, row_in, col_ff, col_in;
   logic [31:0] sv_ff, sv_in, mv_ff, mv_in, rv_ff, rv_in;
   logic [10:0] ridx_ff, ridx_in;
   result_type  res_ff, res_in, rsp_ff, rsp_in;

   logic [15:0]   coord_rd_ff;
   logic [31:0]   stiff_rd_ff, mass_rd_ff, rhs_rd_ff;
   logic [CW-1:0] gp_rd_ff;

   logic          c_we;
   logic [EW-1:0] c_wa, c_ra;
   logic [15:0]   c_wd;
   logic          s_we, ms_we;
   logic [EW-1:0] v_wa;
   logic [31:0]   s_wd, ms_wd;
   logic          gp_we;
   logic [GA-1:0] gp_wa, gp_ra;
   logic [CW-1:0] gp_wd;
   logic          r_we;
   logic [DA-1:0] r_wa, r_ra;
   logic [31:0]   r_wd;

   logic [31:0] add_a, add_b, add_sum;

   always_comb begin
      unique case (state_ff)
         ST_V_ADDS: begin
            add_a = stiff_rd_ff;
            add_b = sv_ff;
         end
         ST_V_ADDM: begin
            add_a = mass_rd_ff;
            add_b = mv_ff;
         end
         default: begin
            add_a = rhs_rd_ff;
            add_b = rv_ff;
         end
      endcase
   end

   assign add_sum = sat_add(add_a, add_b);

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      logic [31:0] t32;
      logic [31:0] u32;
      logic [CW-1:0] inc;
      t32 = '0;
      u32 = '0;
      inc = '0;
      state_in = state_ff;
      cm_in = (csr_valid && csr_ready) ? csr_column_major : cm_ff;
      built_in = built_ff;
      csc_in = csc_ff;
      stored_in = stored_ff;
      groups_in = groups_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      hi_in = hi_ff;
      idx_in = idx_ff;
      m_in = m_ff;
      cur_in = cur_ff;
      last_in = last_ff;
      row_in = row_ff;
      col_in = col_ff;
      sv_in = sv_ff;
      mv_in = mv_ff;
      rv_in = rv_ff;
      ridx_in = ridx_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      c_we = 1'b0;
      c_wa = '0;
      c_wd = '0;
      c_ra = '0;
      s_we = 1'b0;
      ms_we = 1'b0;
      v_wa = idx_ff[EW-1:0];
      s_wd = '0;
      ms_wd = '0;
      gp_we = 1'b0;
      gp_wa = m_ff;
      gp_wd = i_ff;
      gp_ra = '0;
      r_we = 1'b0;
      r_wa = '0;
      r_wd = '0;
      r_ra = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               row_in = req_row;
               col_in = req_col;
               sv_in = req_stiff_value;
               mv_in = req_mass_value;
               rv_in = req_rhs_value;
               ridx_in = req_read_index;
               res_in = '0;
               res_in.status = STS_OK;
               state_in = ST_DONE;
               unique case (req_type)
                  REQ_INSERT: begin
                     if (built_ff) begin
                        res_in.status = STS_PHASE;
                     end else if (32'(req_row) >= MAX_DIM || 32'(req_col) >= MAX_DIM) begin
                        res_in.status = STS_RANGE;
                     end else if (32'(stored_ff) >= MAX_ENTRIES) begin
                        res_in.status = STS_FULL;
                     end else begin
                        c_we = 1'b1;
                        c_wa = stored_ff[EW-1:0];
                        c_wd = {req_row, req_col};
                        stored_in = stored_ff + CW'(1);
                     end
                  end
                  REQ_BUILD: begin
                     if (built_ff) begin
                        res_in.status = STS_PHASE;
                     end else begin
                        csc_in = cm_ff;
                        i_in = CW'(1);
                        state_in = ST_SORT_LD;
                     end
                  end
                  REQ_ADD: begin
                     if (!built_ff) begin
                        res_in.status = STS_PHASE;
                     end else if (32'(req_row) >= MAX_DIM || 32'(req_col) >= MAX_DIM) begin
                        res_in.status = STS_RANGE;
                     end else begin
                        t32 = 32'(csc_ff ? req_col : req_row);
                        gp_ra = t32[GA-1:0];
                        state_in = ST_V_HI;
                     end
                  end
                  REQ_RHS: begin
                     if (!built_ff) begin
                        res_in.status = STS_PHASE;
                     end else if (32'(req_row) >= 32'(groups_ff) || 32'(req_row) >= MAX_DIM) begin
                        res_in.status = STS_RANGE;
                     end else begin
                        t32 = 32'(req_row);
                        r_ra = t32[DA-1:0];
                        state_in = ST_R_ADD;
                     end
                  end
                  REQ_ENTRY: begin
                     if (32'(req_read_index) >= 32'(stored_ff)
                         || 32'(req_read_index) >= MAX_ENTRIES) begin
                        res_in.status = STS_RANGE;
                     end else begin
                        t32 = 32'(req_read_index);
                        idx_in = t32[CW-1:0];
                        state_in = ST_E_WAIT;
                     end
                  end
                  REQ_GROUP: begin
                     if (!built_ff) begin
                        res_in.status = STS_PHASE;
                     end else if (32'(req_read_index) > MAX_DIM) begin
                        res_in.status = STS_RANGE;
                     end else begin
                        t32 = 32'(req_read_index);
                        gp_ra = t32[GA-1:0];
                        r_ra = t32[DA-1:0];
                        state_in = ST_G_GET;
                     end
                  end
                  default: begin
                     res_in.status = STS_RANGE;
                  end
               endcase
            end
         end
         ST_SORT_LD: begin
            if (i_ff >= stored_ff) begin
               i_in = '0;
               k_in = '0;
               groups_in = '0;
               m_in = '0;
               state_in = (stored_ff == '0) ? ST_GP_RD : ST_DD;
            end else begin
               c_ra = i_ff[EW-1:0];
               state_in = ST_SORT_GET;
            end
         end
         ST_SORT_GET: begin
            cur_in = coord_rd_ff;
            j_in = i_ff;
            inc = i_ff - CW'(1);
            c_ra = inc[EW-1:0];
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            c_we = 1'b1;
            c_wa = j_ff[EW-1:0];
            if (key_of(coord_rd_ff, csc_ff) > key_of(cur_ff, csc_ff)) begin
               c_wd = coord_rd_ff;
               j_in = j_ff - CW'(1);
               if (j_ff == CW'(1)) begin
                  state_in = ST_SORT_PUT;
               end else begin
                  inc = j_ff - CW'(2);
                  c_ra = inc[EW-1:0];
               end
            end else begin
               c_wd = cur_ff;
               i_in = i_ff + CW'(1);
               state_in = ST_SORT_LD;
            end
         end
         ST_SORT_PUT: begin
            c_we = 1'b1;
            c_wa = j_ff[EW-1:0];
            c_wd = cur_ff;
            i_in = i_ff + CW'(1);
            state_in = ST_SORT_LD;
         end
         ST_DD: begin
            k_in = k_ff;
            if (k_ff == '0 || last_ff != coord_rd_ff) begin
               c_we = 1'b1;
               c_wa = k_ff[EW-1:0];
               c_wd = coord_rd_ff;
               s_we = 1'b1;
               ms_we = 1'b1;
               v_wa = k_ff[EW-1:0];
               if (k_ff == '0
                   || major_of(coord_rd_ff, csc_ff) != major_of(last_ff, csc_ff)) begin
                  groups_in = groups_ff + GA'(1);
               end
               last_in = coord_rd_ff;
               k_in = k_ff + CW'(1);
            end
            inc = i_ff + CW'(1);
            c_ra = inc[EW-1:0];
            i_in = inc;
            if (inc >= stored_ff) begin
               stored_in = k_in;
               i_in = '0;
               state_in = ST_GP_RD;
            end
         end
         ST_GP_RD: begin
            c_ra = i_ff[EW-1:0];
            state_in = ST_GP;
         end
         ST_GP: begin
            if (i_ff < stored_ff
                && 32'(major_of(coord_rd_ff, csc_ff)) < 32'(m_ff)) begin
               inc = i_ff + CW'(1);
               i_in = inc;
               c_ra = inc[EW-1:0];
            end else begin
               c_ra = i_ff[EW-1:0];
               gp_we = 1'b1;
               if (32'(m_ff) < MAX_DIM) begin
                  r_we = 1'b1;
                  r_wa = m_ff[DA-1:0];
               end
               if (32'(m_ff) == MAX_DIM) begin
                  built_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  m_in = m_ff + GA'(1);
               end
            end
         end
         ST_V_HI: begin
            i_in = gp_rd_ff;
            t32 = 32'(csc_ff ? col_ff : row_ff) + 32'd1;
            gp_ra = t32[GA-1:0];
            state_in = ST_V_START;
         end
         ST_V_START: begin
            hi_in = gp_rd_ff;
            c_ra = i_ff[EW-1:0];
            state_in = ST_V_SCAN;
         end
         ST_V_SCAN: begin
            if (i_ff < hi_ff) begin
               if (coord_rd_ff == {row_ff, col_ff}) begin
                  idx_in = i_ff;
                  state_in = ST_V_WAIT;
               end else begin
                  inc = i_ff + CW'(1);
                  i_in = inc;
                  c_ra = inc[EW-1:0];
               end
            end else begin
               res_in.status = STS_NOTFOUND;
               state_in = ST_DONE;
            end
         end
         ST_V_WAIT: begin
            state_in = ST_V_ADDS;
         end
         ST_V_ADDS: begin
            s_we = 1'b1;
            s_wd = add_sum;
            res_in.ks = add_sum;
            state_in = ST_V_ADDM;
         end
         ST_V_ADDM: begin
            ms_we = 1'b1;
            ms_wd = add_sum;
            res_in.ms = add_sum;
            res_in.minor = csc_ff ? row_ff : col_ff;
            state_in = ST_DONE;
         end
         ST_R_ADD: begin
            t32 = 32'(row_ff);
            r_we = 1'b1;
            r_wa = t32[DA-1:0];
            r_wd = add_sum;
            res_in.rs = add_sum;
            state_in = ST_DONE;
         end
         ST_E_WAIT: begin
            c_ra = idx_ff[EW-1:0];
            state_in = ST_E_GET;
         end
         ST_E_GET: begin
            res_in.minor = minor_of(coord_rd_ff, built_ff ? csc_ff : cm_ff);
            res_in.ks = built_ff ? stiff_rd_ff : '0;
            res_in.ms = built_ff ? mass_rd_ff : '0;
            state_in = ST_DONE;
         end
         ST_G_GET: begin
            t32 = 32'(gp_rd_ff);
            res_in.gs = t32[10:0];
            res_in.rs = (32'(ridx_ff) < MAX_DIM) ? rhs_rd_ff : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               t32 = 32'(stored_ff);
               u32 = 32'(groups_ff);
               rsp_in = res_ff;
               rsp_in.entries = t32[10:0];
               rsp_in.groups = u32[8:0];
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cm_ff <= 1'b0;
         built_ff <= 1'b0;
         csc_ff <= 1'b0;
         stored_ff <= '0;
         groups_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cm_ff <= cm_in;
         built_ff <= built_in;
         csc_ff <= csc_in;
         stored_ff <= stored_in;
         groups_ff <= groups_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      hi_ff <= hi_in;
      idx_ff <= idx_in;
      m_ff <= m_in;
      cur_ff <= cur_in;
      last_ff <= last_in;
      row_ff <= row_in;
      col_ff <= col_in;
      sv_ff <= sv_in;
      mv_ff <= mv_in;
      rv_ff <= rv_in;
      ridx_ff <= ridx_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         coord_mem[c_wa] <= c_wd;
      end
      coord_rd_ff <= coord_mem[c_ra];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         stiff_mem[v_wa] <= s_wd;
      end
      if (ms_we) begin
         mass_mem[v_wa] <= ms_wd;
      end
      stiff_rd_ff <= stiff_mem[idx_ff[EW-1:0]];
      mass_rd_ff <= mass_mem[idx_ff[EW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (gp_we) begin
         gp_mem[gp_wa] <= gp_wd;
      end
      gp_rd_ff <= gp_mem[gp_ra];
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         rhs_mem[r_wa] <= r_wd;
      end
      rhs_rd_ff <= rhs_mem[r_ra];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_minor_index = rsp_ff.minor;
   assign rsp_stiff_sum = rsp_ff.ks;
   assign rsp_mass_sum = rsp_ff.ms;
   assign rsp_group_start = rsp_ff.gs;
   assign rsp_rhs_sum = rsp_ff.rs;
   assign rsp_entry_count = rsp_ff.entries;
   assign rsp_group_count = rsp_ff.groups;

   a_stored_bound: assert property (@(posedge clock) disable iff (reset)
      32'(stored_ff) <= MAX_ENTRIES)
      else $error("entry count above capacity");

   a_built_holds: assert property (@(posedge clock) disable iff (reset)
      built_ff |=> built_ff)
      else $error("built flag dropped");

   a_groups_bound: assert property (@(posedge clock) disable iff (reset)
      built_ff |-> 32'(groups_ff) <= 32'(stored_ff))
      else $error("more groups than entries");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside completion");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_V_SCAN |-> i_ff <= hi_ff)
      else $error("group scan ran past group end");

endmodule

// File: verif/spa_checker.sv
// Checker for sparse_pattern_assembler: watches the config, request and result
// channels, predicts every result and compares it field by field. Uses spa_pkg.
module spa_checker #(
   parameter int MAX_ENTRIES = 1024,
   parameter int MAX_DIM     = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_column_major,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic [7:0]         req_row,
   input  logic [7:0]         req_col,
   input  logic signed [31:0] req_stiff_value,
   input  logic signed [31:0] req_mass_value,
   input  logic signed [31:0] req_rhs_value,
   input  logic [10:0]        req_read_index,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_status,
   input  logic [7:0]         rsp_minor_index,
   input  logic signed [31:0] rsp_stiff_sum,
   input  logic signed [31:0] rsp_mass_sum,
   input  logic [10:0]        rsp_group_start,
   input  logic signed [31:0] rsp_rhs_sum,
   input  logic [10:0]        rsp_entry_count,
   input  logic [8:0]         rsp_group_count,
   output int                 errors,
   output int                 results_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import spa_pkg::*;

   bit [15:0]        coords [MAX_ENTRIES];
   bit signed [31:0] stiff  [MAX_ENTRIES];
   bit signed [31:0] mass   [MAX_ENTRIES];
   bit [10:0]        gptr   [MAX_DIM+1];
   bit signed [31:0] rhs    [MAX_DIM];
   int               n_entries;
   int               n_groups;
   bit               built;
   bit               built_csc;
   bit               live_csc;
   result_type       expected_q [$];

   function automatic bit [7:0] major_of(bit [15:0] c, bit csc);
      return csc ? c[7:0] : c[15:8];
   endfunction

   function automatic bit [7:0] minor_of(bit [15:0] c, bit csc);
      return csc ? c[15:8] : c[7:0];
   endfunction

   function automatic bit [15:0] order_key(bit [15:0] c, bit csc);
      return {major_of(c, csc), minor_of(c, csc)};
   endfunction

   function automatic bit signed [31:0] sat_add(bit signed [31:0] a, bit signed [31:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > 64'sh7FFFFFFF) s = 64'sh7FFFFFFF;
      if (s < -64'sh80000000) s = -64'sh80000000;
      return s[31:0];
   endfunction

   task automatic build_pattern();
      bit [15:0] c;
      int        j;
      int        n;
      bit [7:0]  m;
      bit [7:0]  prev;
      for (int i = 1; i < n_entries; i++) begin
         c = coords[i];
         j = i;
         while (j > 0 && order_key(coords[j-1], live_csc) > order_key(c, live_csc)) begin
            coords[j] = coords[j-1];
            j--;
         end
         coords[j] = c;
      end
      n = 0;
      for (int i = 0; i < n_entries; i++)
         if (n == 0 || coords[n-1] != coords[i]) begin
            coords[n] = coords[i];
            n++;
         end
      n_entries = n;
      foreach (stiff[i]) begin
         stiff[i] = 0;
         mass[i]  = 0;
      end
      foreach (rhs[i]) rhs[i] = 0;
      foreach (gptr[i]) gptr[i] = 0;
      n_groups = 0;
      prev = 0;
      for (int i = 0; i < n; i++) begin
         m = major_of(coords[i], live_csc);
         gptr[int'(m) + 1]++;
         if (i == 0 || m != prev) n_groups++;
         prev = m;
      end
      for (int i = 1; i <= MAX_DIM; i++) gptr[i] += gptr[i-1];
      built_csc = live_csc;
      built = 1;
   endtask

   task automatic predict_result();
      result_type e;
      bit [15:0]  c;
      int         m;
      e = '0;
      c = {req_row, req_col};
      case (req_type)
         REQ_INSERT: begin
            if (built) e.status = STS_PHASE;
            else if (n_entries >= MAX_ENTRIES) e.status = STS_FULL;
            else begin
               coords[n_entries] = c;
               n_entries++;
            end
         end
         REQ_BUILD: begin
            if (built) e.status = STS_PHASE;
            else build_pattern();
         end
         REQ_ADD: begin
            if (!built) e.status = STS_PHASE;
            else begin
               m = int'(built_csc ? req_col : req_row);
               e.status = STS_NOTFOUND;
               for (int i = gptr[m]; i < gptr[m+1]; i++)
                  if (coords[i] == c) begin
                     stiff[i] = sat_add(stiff[i], req_stiff_value);
                     mass[i]  = sat_add(mass[i], req_mass_value);
                     e.ks     = stiff[i];
                     e.ms     = mass[i];
                     e.minor  = minor_of(c, built_csc);
                     e.status = STS_OK;
                     break;
                  end
            end
         end
         REQ_RHS: begin
            if (!built) e.status = STS_PHASE;
            else if (req_row >= n_groups) e.status = STS_RANGE;
            else begin
               rhs[req_row] = sat_add(rhs[req_row], req_rhs_value);
               e.rs = rhs[req_row];
            end
         end
         REQ_ENTRY: begin
            if (req_read_index >= n_entries) e.status = STS_RANGE;
            else begin
               e.minor = minor_of(coords[req_read_index], built ? built_csc : live_csc);
               e.ks    = stiff[req_read_index];
               e.ms    = mass[req_read_index];
            end
         end
         REQ_GROUP: begin
            if (!built) e.status = STS_PHASE;
            else if (req_read_index > MAX_DIM) e.status = STS_RANGE;
            else begin
               e.gs = gptr[req_read_index];
               if (req_read_index < MAX_DIM) e.rs = rhs[req_read_index];
            end
         end
         default: e.status = STS_RANGE;
      endcase
      e.entries = 11'(n_entries);
      e.groups  = 9'(n_groups);
      expected_q = {expected_q, e};
   endtask

   task automatic report(string field, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      errors++;
   endtask

   task automatic check_result();
      result_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: result item with nothing expected", $realtime);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (rsp_status !== e.status) report("status", rsp_status, e.status);
      if (rsp_minor_index !== e.minor) report("minor_index", rsp_minor_index, e.minor);
      if (rsp_stiff_sum !== e.ks) report("stiff_sum", rsp_stiff_sum, e.ks);
      if (rsp_mass_sum !== e.ms) report("mass_sum", rsp_mass_sum, e.ms);
      if (rsp_group_start !== e.gs) report("group_start", rsp_group_start, e.gs);
      if (rsp_rhs_sum !== e.rs) report("rhs_sum", rsp_rhs_sum, e.rs);
      if (rsp_entry_count !== e.entries) report("entry_count", rsp_entry_count, e.entries);
      if (rsp_group_count !== e.groups) report("group_count", rsp_group_count, e.groups);
   endtask

   initial begin
      errors       = 0;
      results_seen = 0;
      n_entries    = 0;
      n_groups     = 0;
      built        = 0;
      built_csc    = 0;
      live_csc     = 0;
      foreach (coords[i]) begin
         coords[i] = 0;
         stiff[i]  = 0;
         mass[i]   = 0;
      end
      foreach (gptr[i]) gptr[i] = 0;
      foreach (rhs[i]) rhs[i] = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) live_csc = csr_column_major;
         if (req_valid && !req_stall) predict_result();
         if (rsp_valid && !rsp_stall) begin
            check_result();
            results_seen <= results_seen + 1;
         end
      end
   end

endmodule

// File: verif/tb_top.sv
// Top of the sparse_pattern_assembler testbench: clock, reset, stimulus and verdict.
// Depends on spa_pkg, sparse_pattern_assembler and spa_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import spa_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_column_major;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_type;
   logic [7:0]         req_row;
   logic [7:0]         req_col;
   logic signed [31:0] req_stiff_value;
   logic signed [31:0] req_mass_value;
   logic signed [31:0] req_rhs_value;
   logic [10:0]        req_read_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [2:0]         rsp_status;
   logic [7:0]         rsp_minor_index;
   logic signed [31:0] rsp_stiff_sum;
   logic signed [31:0] rsp_mass_sum;
   logic [10:0]        rsp_group_start;
   logic signed [31:0] rsp_rhs_sum;
   logic [10:0]        rsp_entry_count;
   logic [8:0]         rsp_group_count;
   int                 errors;
   int                 results_seen;
   int                 items_sent;
   int                 quiet_cycles = 0;
   bit                 no_idle;
   int                 inserted;
   bit [7:0]           known_row [$];
   bit [7:0]           known_col [$];

   sparse_pattern_assembler i_dut (.*);

   spa_checker i_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic send(bit [2:0] t, bit [7:0] r, bit [7:0] c, bit [31:0] ks,
                       bit [31:0] ms, bit [31:0] rs, bit [10:0] ri);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= t;
      req_row         <= r;
      req_col         <= c;
      req_stiff_value <= ks;
      req_mass_value  <= ms;
      req_rhs_value   <= rs;
      req_read_index  <= ri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_seen != items_sent) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_layout(bit csc);
      csr_valid        <= 1'b1;
      csr_column_major <= csc;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic bit [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 255) << 12;
         default: return $urandom();
      endcase
   endfunction

   task automatic insert(bit [7:0] r, bit [7:0] c);
      send(REQ_INSERT, r, c, $urandom(), $urandom(), $urandom(), 11'($urandom()));
      if (inserted < 1024) begin
         inserted++;
         known_row = {known_row, r};
         known_col = {known_col, c};
      end
   endtask

   // always
   always begin
      int n;
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
         rsp_stall <= 1'b1;
         repeat (n) @(posedge clock);
      end
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (!rsp_valid || rsp_stall) @(posedge clock);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int k;
      int pick;
      bit [7:0] r;
      bit [7:0] c;
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_column_major = 1'b0;
      req_valid        = 1'b0;
      req_type         = REQ_INSERT;
      req_row          = '0;
      req_col          = '0;
      req_stiff_value  = '0;
      req_mass_value   = '0;
      req_rhs_value    = '0;
      req_read_index   = '0;
      rsp_stall        = 1'b1;
      items_sent       = 0;
      no_idle          = 0;
      inserted         = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: before build
      write_layout(1'b1);
      send(3'd6, 0, 0, 0, 0, 0, 0);
      send(3'd7, 8'hFF, 8'hFF, '1, '1, '1, '1);
      send(REQ_GROUP, 0, 0, 0, 0, 0, 0);
      send(REQ_ADD, 0, 0, 1, 1, 1, 0);
      send(REQ_RHS, 0, 0, 0, 0, 1, 0);
      send(REQ_ENTRY, 0, 0, 0, 0, 0, 0);
      insert(8'h00, 8'h00);
      insert(8'hFF, 8'hFF);
      insert(8'h00, 8'hFF);
      insert(8'hFF, 8'h00);
      for (int i = 0; i < 4; i++) send(REQ_ENTRY, 0, 0, 0, 0, 0, 11'(i));
      send(REQ_ENTRY, 0, 0, 0, 0, 0, 11'h7FF);
      wait_idle();
      write_layout(1'b0);
      for (int i = 0; i < 4; i++) send(REQ_ENTRY, 0, 0, 0, 0, 0, 11'(i));
      wait_idle();
      write_layout(1'b1);

      // random collection: small column range so groups hold several entries
      for (int i = 0; i < 80; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            r = 8'($urandom_range(0, 255));
            c = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 239)
                                               : $urandom_range(0, 7));
            insert(r, c);
         end else if (pick < 7 && known_row.size() > 0) begin
            k = $urandom_range(0, known_row.size() - 1);
            insert(known_row[k], known_col[k]);
         end else if (pick < 9)
            send(REQ_ENTRY, 0, 0, 0, 0, 0, 11'($urandom_range(0, inserted + 2)));
         else
            send(3'($urandom_range(6, 7)), 8'($urandom()), 8'($urandom()), $urandom(),
                 $urandom(), $urandom(), 11'($urandom()));
      end

      insert(8'h12, 8'h34);
      insert(8'hFF, 8'hFF);
      wait_idle();
      write_layout(1'b0);
      wait_idle();
      write_layout(1'b1);

      send(REQ_BUILD, 0, 0, 0, 0, 0, 0);
      send(REQ_BUILD, 0, 0, 0, 0, 0, 0);
      insert(8'h01, 8'h01);
      send(REQ_GROUP, 0, 0, 0, 0, 0, 11'd256);
      send(REQ_GROUP, 0, 0, 0, 0, 0, 11'd257);
      send(REQ_RHS, 8'hFF, 0, 0, 0, 32'h7FFFFFFF, 0);
      for (int i = 0; i < 3; i++)
         send(REQ_ADD, known_row[0], known_col[0], 32'h7FFFFFFF, 32'h80000000, 0, 0);
      for (int i = 0; i < 3; i++)
         send(REQ_RHS, 0, 0, 0, 0, 32'h80000000, 0);

      // random operation after build
      for (int i = 0; i < 440; i++) begin
         no_idle = (i >= 150 && i < 230);
         if (i == 300) begin
            wait_idle();
            write_layout(1'b0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            k = $urandom_range(0, known_row.size() - 1);
            send(REQ_ADD, known_row[k], known_col[k], rand_value(), rand_value(),
                 $urandom(), 11'($urandom()));
         end else if (pick < 55)
            send(REQ_ADD, 8'($urandom()), 8'($urandom()), rand_value(), rand_value(), 0, 0);
         else if (pick < 70)
            send(REQ_RHS, 8'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 15)),
                 8'($urandom()), 0, 0, rand_value(), 0);
         else if (pick < 80)
            send(REQ_ENTRY, 0, 0, 0, 0, 0,
                 11'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1023)));
         else if (pick < 90)
            send(REQ_GROUP, 0, 0, 0, 0, 0,
                 11'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 257)));
         else if (pick < 95)
            send(3'($urandom_range(6, 7)), 8'($urandom()), 8'($urandom()), $urandom(),
                 $urandom(), $urandom(), 11'($urandom()));
         else
            send(3'($urandom_range(0, 1)), 8'($urandom()), 8'($urandom()), 0, 0, 0, 0);
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0 && results_seen == items_sent)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/spa_pkg.sv
rtl/sparse_pattern_assembler.sv
verif/spa_checker.sv
verif/tb_top.sv
